// ----- rtl/sorted_priority_queue_insert_macros.svh -----
// assertion macros for the sorted priority queue insert block
// used by modules that check their own control logic, no other dependencies
`ifndef SORTED_PRIORITY_QUEUE_INSERT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_INSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SPQI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spqi check failed");

// next-cycle implication, checked out of reset
`define SPQI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spqi check failed");

`endif

// ----- rtl/spqi_pkg.sv -----
// shared types and codes for the sorted priority queue insert block
// no dependencies
package spqi_pkg;

	localparam int QUEUE_DEPTH_DEFAULT = 16;
	localparam int TAG_W = 32;
	localparam int PRIO_W = 16;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_DUMP = 1'b1;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ENTRY = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// commands from the controller to the cell chain
	typedef struct packed {
		logic insert;
		logic rotate;
		logic capture;
		logic clear_out;
	} spqi_cmd_t;

	// queue status back to the controller
	typedef struct packed {
		logic empty;
		logic full;
	} spqi_stat_t;

endpackage

// ----- rtl/spqi_datapath.sv -----
// cell chain holding the sorted entries, entry count and read-out registers
// depends on spqi_pkg
module spqi_datapath import spqi_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH_DEFAULT,
	localparam int CW = $clog2(QueueDepth + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  spqi_cmd_t                cmd,
	input  logic [TAG_W-1:0]         tag,
	input  logic signed [PRIO_W-1:0] priority_req,
	output spqi_stat_t               stat,
	output logic [CW-1:0]            count,
	output logic [TAG_W-1:0]         out_tag,
	output logic signed [PRIO_W-1:0] out_priority
);

	logic [TAG_W-1:0]         tag_q [QueueDepth];
	logic signed [PRIO_W-1:0] prio_q [QueueDepth];
	logic [CW-1:0]            count_q;
	logic [QueueDepth-1:0]    ge;
	logic [TAG_W-1:0]         out_tag_q;
	logic signed [PRIO_W-1:0] out_prio_q;

	// stored entries at or above the new priority form a prefix of the chain
	always_comb begin
		for (int i = 0; i < QueueDepth; i++) begin
			ge[i] = (CW'(i) < count_q) && (prio_q[i] >= priority_req);
		end
	end

	for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (cmd.insert) begin
					if (!ge[0]) begin
						tag_q[0] <= tag;
						prio_q[0] <= priority_req;
					end
				end else if (cmd.rotate) begin
					if (count_q == CW'(1)) begin
						tag_q[0] <= tag_q[0];
						prio_q[0] <= prio_q[0];
					end else begin
						tag_q[0] <= tag_q[1];
						prio_q[0] <= prio_q[1];
					end
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (cmd.insert) begin
					if (!ge[i]) begin
						if (!ge[i-1]) begin
							tag_q[i] <= tag_q[i-1];
							prio_q[i] <= prio_q[i-1];
						end else begin
							tag_q[i] <= tag;
							prio_q[i] <= priority_req;
						end
					end
				end else if (cmd.rotate) begin
					// the occupied tail wraps round to the head
					if (i == QueueDepth - 1 || CW'(i + 1) == count_q) begin
						tag_q[i] <= tag_q[0];
						prio_q[i] <= prio_q[0];
					end else begin
						tag_q[i] <= tag_q[(i + 1) % QueueDepth];
						prio_q[i] <= prio_q[(i + 1) % QueueDepth];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			out_tag_q <= tag_q[0];
			out_prio_q <= prio_q[0];
		end else if (cmd.clear_out) begin
			out_tag_q <= '0;
			out_prio_q <= '0;
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.full = (count_q == CW'(QueueDepth));
	assign count = count_q;
	assign out_tag = out_tag_q;
	assign out_priority = out_prio_q;

endmodule

// ----- rtl/spqi_ctrl.sv -----
// controller: request decode, dump sequencing and result strobe
// depends on spqi_pkg and the assertion macro header
`include "sorted_priority_queue_insert_macros.svh"
module spqi_ctrl import spqi_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH_DEFAULT,
	localparam int CW = $clog2(QueueDepth + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          mode,
	input  spqi_stat_t    stat,
	input  logic [CW-1:0] count,
	output logic          busy,
	output spqi_cmd_t     cmd,
	output logic          strobe,
	output logic [1:0]    status,
	output logic          last
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] idx_q, idx_d;
	logic          strobe_q, strobe_d;
	logic          last_q, last_d;
	logic [1:0]    status_q, status_d;
	logic          accept;

	assign busy = (state_q == S_DUMP);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		strobe_d = 1'b0;
		last_d = 1'b0;
		status_d = status_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mode == MODE_INSERT) begin
						cmd.insert = !stat.full;
						cmd.clear_out = 1'b1;
						strobe_d = 1'b1;
						last_d = 1'b1;
						status_d = stat.full ? ST_FULL : ST_INSERTED;
					end else if (stat.empty) begin
						cmd.clear_out = 1'b1;
						strobe_d = 1'b1;
						last_d = 1'b1;
						status_d = ST_EMPTY;
					end else begin
						state_d = S_DUMP;
						idx_d = '0;
					end
				end
			end
			S_DUMP: begin
				// head goes out, chain rotates so the next entry reaches the head
				cmd.capture = 1'b1;
				cmd.rotate = 1'b1;
				strobe_d = 1'b1;
				status_d = ST_ENTRY;
				last_d = (idx_q + CW'(1) == count);
				if (last_d) begin
					state_d = S_IDLE;
				end else begin
					idx_d = idx_q + CW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			strobe_q <= 1'b0;
			last_q <= 1'b0;
			status_q <= ST_INSERTED;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			strobe_q <= strobe_d;
			last_q <= last_d;
			status_q <= status_d;
		end
	end

	assign strobe = strobe_q;
	assign status = status_q;
	assign last = last_q;

	`SPQI_ASSERT_NOW(a_idx_in_range, clk, arst_n, state_q == S_DUMP, idx_q < count)
	`SPQI_ASSERT_NEXT(a_insert_one_result, clk, arst_n, accept && mode == MODE_INSERT,
		strobe_q && last_q && !busy)
	`SPQI_ASSERT_NEXT(a_dump_starts, clk, arst_n, accept && mode == MODE_DUMP && !stat.empty,
		busy && !strobe_q)
	`SPQI_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count <= CW'(QueueDepth))
	`SPQI_ASSERT_NOW(a_entry_status, clk, arst_n, strobe_q && status_q == ST_ENTRY,
		!stat.empty)

endmodule

// ----- rtl/sorted_priority_queue_insert.sv -----
// top level of the sorted priority queue with stable insert
// depends on spqi_pkg, spqi_ctrl and spqi_datapath
//
//   channel   handshake          fields
//   request   start / busy       mode, tag, priority_req
//   result    strobe             status, out_tag, out_priority, last
//
// an insert is taken while busy is low and its status appears in the next cycle; inserts
// may follow back to back since all cells compare and shift in the same cycle
// a dump holds busy while the stored entries are rotated out, one entry per cycle,
// from the cell chain head; results appear in the cycle after the one that produced them
// reset empties the queue; the receiver cannot stall, each strobe lasts one cycle
module sorted_priority_queue_insert import spqi_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     mode,
	input  logic [TAG_W-1:0]         tag,
	input  logic signed [PRIO_W-1:0] priority_req,
	output logic                     strobe,
	output logic [1:0]               status,
	output logic [TAG_W-1:0]         out_tag,
	output logic signed [PRIO_W-1:0] out_priority,
	output logic                     last
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	spqi_cmd_t     cmd;
	spqi_stat_t    stat;
	logic [CW-1:0] count;

	spqi_ctrl #(
		.QueueDepth(QUEUE_DEPTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.count  (count),
		.busy   (busy),
		.cmd    (cmd),
		.strobe (strobe),
		.status (status),
		.last   (last)
	);

	spqi_datapath #(
		.QueueDepth(QUEUE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.tag          (tag),
		.priority_req (priority_req),
		.stat         (stat),
		.count        (count),
		.out_tag      (out_tag),
		.out_priority (out_priority)
	);

endmodule
